FILE: design/occ_pkg.sv
// Shared types, state codes and character helpers for the checksum encoder.
`default_nettype none

package occ_pkg;

	// Number of characters in the encoded checksum and in one output chunk
	localparam int unsigned NumChars  = 16;
	localparam int unsigned ChunkLen  = 8;
	localparam int unsigned NumBytes  = 4;

	// Offset of the character alphabet
	localparam logic [7:0] CharBase = 8'h30;

	// One input item: a message word
	typedef struct packed {
		logic [31:0] data_word;
		logic        last_word;
	} in_item_t;

	// One result item: half of the encoded checksum
	typedef struct packed {
		logic [31:0] sum_value;
		logic [63:0] text_chunk;
		logic        chunk_index;
		logic        last_chunk;
	} out_item_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_ACCUM,
		ST_LOAD,
		ST_FIX,
		ST_OUT0,
		ST_OUT1
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic add_word;
		logic seed_sel;
		logic load_text;
		logic fix_step;
		logic chunk_sel;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic fix_done;
	} status_t;

	// True for the punctuation codes the encoding must avoid
	function automatic logic is_punct(input logic [7:0] c);
		return c inside {[8'h3a:8'h40], [8'h5b:8'h60]};
	endfunction

endpackage

`default_nettype wire

FILE: design/occ_ctrl.sv
// Controller state machine: message framing, encode sequencing and output handshake.
`default_nettype none

module occ_ctrl import occ_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    word_valid,
	input  wire logic    word_last,
	output logic         word_ready,
	output logic         chunk_valid,
	input  wire logic    chunk_ready,
	input  wire status_t status,
	output cmd_t         cmd
);

	state_t state_q;
	state_t state_d;
	logic   mid_q;
	logic   word_acc;

	assign word_acc = word_valid && word_ready;

	// State and message-open flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCUM;
			mid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (word_acc) begin
				mid_q <= !word_last;
			end
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_ACCUM: begin
				if (word_valid && word_last) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				state_d = ST_FIX;
			end
			ST_FIX: begin
				if (status.fix_done) begin
					state_d = ST_OUT0;
				end
			end
			ST_OUT0: begin
				if (chunk_ready) begin
					state_d = ST_OUT1;
				end
			end
			ST_OUT1: begin
				if (chunk_ready) begin
					state_d = ST_ACCUM;
				end
			end
			default: begin
				state_d = ST_ACCUM;
			end
		endcase
	end

	// Outputs and datapath commands
	always_comb begin
		word_ready    = 1'b0;
		chunk_valid   = 1'b0;
		cmd           = '0;
		case (state_q)
			ST_ACCUM: begin
				word_ready    = 1'b1;
				cmd.add_word  = word_valid;
				cmd.seed_sel  = !mid_q;
			end
			ST_LOAD: begin
				cmd.load_text = 1'b1;
			end
			ST_FIX: begin
				cmd.fix_step  = !status.fix_done;
			end
			ST_OUT0: begin
				chunk_valid   = 1'b1;
			end
			ST_OUT1: begin
				chunk_valid   = 1'b1;
				cmd.chunk_sel = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: design/occ_dpath.sv
// Datapath: seed register, end-around-carry accumulator and character encoder.
`default_nettype none

module occ_dpath import occ_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata,
	input  wire logic [31:0] data_word,
	input  wire cmd_t        cmd,
	output status_t          status,
	output out_item_t        chunk
);

	logic [31:0] seed_q;
	logic [31:0] sum_q;
	logic [31:0] base;
	logic [32:0] wide_sum;
	logic [31:0] eac_sum;
	logic [31:0] inv_sum;
	logic [7:0]  char_q [NumChars];
	logic [7:0]  load_char [NumChars];
	logic [7:0]  fix_char [NumChars];
	logic        any_punct;
	logic [63:0] text0;
	logic [63:0] text1;

	// Seed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cfg_we) begin
			seed_q <= cfg_wdata;
		end
	end

	// Ones'-complement add with the carry folded back into bit 0
	always_comb begin
		base     = cmd.seed_sel ? seed_q : sum_q;
		wide_sum = {1'b0, base} + {1'b0, data_word};
		eac_sum  = wide_sum[31:0] + {31'd0, wide_sum[32]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (cmd.add_word) begin
			sum_q <= eac_sum;
		end
	end

	// Initial characters: four per byte of the complemented sum
	always_comb begin
		logic [7:0] byte_v;
		logic [7:0] q;
		inv_sum = ~sum_q;
		for (int b = 0; b < NumBytes; b++) begin
			byte_v = inv_sum[8*(NumBytes-1-b) +: 8];
			q      = CharBase + {2'b00, byte_v[7:2]};
			load_char[b]                = q + {6'd0, byte_v[1:0]};
			load_char[NumBytes + b]     = q;
			load_char[2*NumBytes + b]   = q;
			load_char[3*NumBytes + b]   = q;
		end
	end

	// One adjustment step: each pair holding punctuation moves apart by one
	always_comb begin
		any_punct = 1'b0;
		for (int i = 0; i < NumChars; i++) begin
			fix_char[i] = char_q[i];
		end
		for (int p = 0; p < 2; p++) begin
			for (int b = 0; b < NumBytes; b++) begin
				if (is_punct(char_q[2*NumBytes*p + b]) ||
				    is_punct(char_q[2*NumBytes*p + NumBytes + b])) begin
					any_punct = 1'b1;
					fix_char[2*NumBytes*p + b]            = char_q[2*NumBytes*p + b] + 8'd1;
					fix_char[2*NumBytes*p + NumBytes + b] =
						char_q[2*NumBytes*p + NumBytes + b] - 8'd1;
				end
			end
		end
	end

	assign status.fix_done = !any_punct;

	// Character store
	always_ff @(posedge clk) begin
		for (int i = 0; i < NumChars; i++) begin
			if (cmd.load_text) begin
				char_q[i] <= load_char[i];
			end else if (cmd.fix_step) begin
				char_q[i] <= fix_char[i];
			end
		end
	end

	// Output text, rotated right by one character
	always_comb begin
		for (int i = 0; i < ChunkLen; i++) begin
			text0[8*(ChunkLen-1-i) +: 8] = char_q[(i + NumChars - 1) % NumChars];
			text1[8*(ChunkLen-1-i) +: 8] = char_q[(i + ChunkLen + NumChars - 1) % NumChars];
		end
	end

	assign chunk.sum_value   = sum_q;
	assign chunk.text_chunk  = cmd.chunk_sel ? text1 : text0;
	assign chunk.chunk_index = cmd.chunk_sel;
	assign chunk.last_chunk  = cmd.chunk_sel;

endmodule

`default_nettype wire

FILE: design/ones_complement_checksum_ascii_encode.sv
// Top level of the ones'-complement checksum with ASCII encoding.
//
//  Channel  Signals                          Direction  Item
//  word     word_valid/word_ready/word       in         32-bit message word + last flag
//  chunk    chunk_valid/chunk_ready/chunk    out        8 encoded characters + sum
//  cfg      cfg_we/cfg_wdata                 in         seed of the running sum
//
// Words that are not marked last may arrive back to back.
// A last word is followed by a load state, then by the adjustment steps of the
// character fixer and a check that sees the settled text (at most seven steps,
// for a pair that starts at the low edge of a punctuation range), then by the
// two chunks, one per cycle while chunk_ready is high.
// No word is taken from the last word until the second chunk leaves.
// Reset clears the seed, the running sum and the message-open flag.
// A stalled chunk holds its value; stalls on either side only add wait cycles.
`default_nettype none

module ones_complement_checksum_ascii_encode import occ_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata,
	input  wire logic        word_valid,
	output logic             word_ready,
	input  wire in_item_t    word,
	output logic             chunk_valid,
	input  wire logic        chunk_ready,
	output out_item_t        chunk
);

	cmd_t    cmd;
	status_t status;

	occ_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.word_valid  (word_valid),
		.word_last   (word.last_word),
		.word_ready  (word_ready),
		.chunk_valid (chunk_valid),
		.chunk_ready (chunk_ready),
		.status      (status),
		.cmd         (cmd)
	);

	occ_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.data_word (word.data_word),
		.cmd       (cmd),
		.status    (status),
		.chunk     (chunk)
	);

	// Words and chunks never move in the same cycle
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(word_ready && chunk_valid))
		else $error("word channel open while a chunk is pending");

	// A last word closes the input until its chunks are out
	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(word_valid && word_ready && word.last_word) |=> !word_ready)
		else $error("input still open after last word");

	// The first chunk is followed by the second
	a_chunk_order: assert property (@(posedge clk) disable iff (!arst_n)
		(chunk_valid && chunk_ready && !chunk.chunk_index) |=>
		(chunk_valid && chunk.chunk_index))
		else $error("second chunk missing after first");

	// The sum stays fixed while chunks are delivered
	a_sum_held: assert property (@(posedge clk) disable iff (!arst_n)
		(chunk_valid && $past(chunk_valid)) |-> $stable(chunk.sum_value))
		else $error("sum changed during chunk delivery");

endmodule

`default_nettype wire

FILE: dv/ones_complement_checksum_ascii_encode_tb.sv
// Testbench for the ones' complement checksum encoder: directed and random messages, scored per chunk.
module ones_complement_checksum_ascii_encode_tb;
	import occ_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ResetCycles   = 5;
	localparam int SettleCycles  = 24;   // load + worst fixer run + both chunks, with margin
	localparam int HoldOffCycles = 200;
	localparam int WatchdogLimit = 2000;
	localparam int WordsPerPhase = 250;
	localparam int NumPhases     = 6;
	localparam int FixPassLimit  = 64;
	localparam int NumPunct      = 13;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;
	logic        word_valid = 1'b0;
	logic        word_ready;
	in_item_t    word_item = '0;
	logic        chunk_valid;
	logic        chunk_ready = 1'b0;
	out_item_t   chunk_item;

	// Predictor state
	logic [31:0] seed_model = '0;
	logic [31:0] sum_model = '0;
	bit          msg_open = 1'b0;
	out_item_t   pending_chunks[$];

	// Traffic shaping
	bit word_gaps_on = 1'b0;
	bit chunk_stalls_on = 1'b0;
	int hold_cycles = 0;
	int stall_left = 0;

	int error_count = 0;
	int quiet_cycles = 0;

	ones_complement_checksum_ascii_encode uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.word_valid(word_valid),
		.word_ready(word_ready),
		.word(word_item),
		.chunk_valid(chunk_valid),
		.chunk_ready(chunk_ready),
		.chunk(chunk_item)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Encode a 32-bit value as 16 characters, first character in the top byte
	function automatic logic [127:0] encode_ascii(input logic [31:0] value);
		logic [7:0]   spread [16];
		logic [127:0] text;
		logic [7:0]   octet;
		int           c [4];
		int           b, j, k, pass, code;
		bit           changed;
		text = '0;
		for (b = 0; b < 4; b++) begin
			octet = value[(3 - b) * 8 +: 8];
			c[1] = int'(octet >> 2) + int'(CharBase);
			c[0] = c[1] + int'(octet[1:0]);
			c[2] = c[1];
			c[3] = c[1];
			changed = 1'b1;
			// nudge pairs apart until no character is punctuation
			for (pass = 0; changed && pass < FixPassLimit; pass++) begin
				changed = 1'b0;
				for (k = 0; k < NumPunct; k++) begin
					code = (k < 7) ? ('h3a + k) : ('h5b + k - 7);
					for (j = 0; j < 4; j += 2) begin
						if (c[j] == code || c[j + 1] == code) begin
							c[j]++;
							c[j + 1]--;
							changed = 1'b1;
						end
					end
				end
			end
			for (j = 0; j < 4; j++)
				spread[4 * j + b] = 8'(c[j]);
		end
		// rotate right by one character
		for (b = 0; b < 16; b++)
			text[127 - 8 * b -: 8] = spread[(b + 15) % 16];
		return text;
	endfunction

	// Fold one accepted word into the running sum; on the last word queue both chunks
	task automatic absorb_word(input in_item_t w);
		logic [32:0]  total;
		logic [127:0] text;
		out_item_t    exp_chunk;
		if (!msg_open)
			sum_model = seed_model;
		total = {1'b0, sum_model} + {1'b0, w.data_word};
		sum_model = total[31:0] + {31'b0, total[32]};
		if (!w.last_word) begin
			msg_open = 1'b1;
		end else begin
			msg_open = 1'b0;
			text = encode_ascii(~sum_model);
			exp_chunk.sum_value = sum_model;
			exp_chunk.text_chunk = text[127:64];
			exp_chunk.chunk_index = 1'b0;
			exp_chunk.last_chunk = 1'b0;
			pending_chunks.push_back(exp_chunk);
			exp_chunk.text_chunk = text[63:0];
			exp_chunk.chunk_index = 1'b1;
			exp_chunk.last_chunk = 1'b1;
			pending_chunks.push_back(exp_chunk);
		end
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		error_count++;
		$display("MISMATCH %s: got %h, expected %h", what, got, want);
	endtask

	// Offer one word and hold it until accepted, then maybe idle a little
	task automatic offer_word(input logic [31:0] data, input logic last);
		in_item_t w;
		w.data_word = data;
		w.last_word = last;
		word_item <= w;
		word_valid <= 1'b1;
		@(posedge clk);
		while (!word_ready)
			@(posedge clk);
		absorb_word(w);
		if (word_gaps_on && $urandom_range(0, 3) == 0) begin
			word_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	function automatic logic [31:0] random_word();
		case ($urandom_range(0, 9))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_message(input int len);
		int i;
		for (i = 0; i < len; i++)
			offer_word(random_word(), i == len - 1);
	endtask

	// Stop sending, wait for every expected chunk, then let the block go quiet
	task automatic settle_idle();
		word_valid <= 1'b0;
		@(posedge clk);
		while (pending_chunks.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// Seed write; only called while the block is idle
	task automatic load_seed(input logic [31:0] value);
		cfg_wdata <= value;
		cfg_we <= 1'b1;
		@(posedge clk);
		seed_model = value;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Receiver: long hold-off, random short stalls, or always ready
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles--;
			chunk_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			chunk_ready <= 1'b0;
		end else if (chunk_stalls_on && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(1, 3) - 1;
			chunk_ready <= 1'b0;
		end else begin
			chunk_ready <= 1'b1;
		end
	end

	// Score each chunk against the oldest expectation
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && chunk_valid && chunk_ready) begin
			if (pending_chunks.size() == 0) begin
				report_mismatch("unexpected chunk", chunk_item.text_chunk, '0);
			end else begin
				want = pending_chunks.pop_front();
				if (chunk_item.sum_value !== want.sum_value)
					report_mismatch("sum_value", 64'(chunk_item.sum_value),
						64'(want.sum_value));
				if (chunk_item.text_chunk !== want.text_chunk)
					report_mismatch("text_chunk", chunk_item.text_chunk, want.text_chunk);
				if (chunk_item.chunk_index !== want.chunk_index)
					report_mismatch("chunk_index", 64'(chunk_item.chunk_index),
						64'(want.chunk_index));
				if (chunk_item.last_chunk !== want.last_chunk)
					report_mismatch("last_chunk", 64'(chunk_item.last_chunk),
						64'(want.last_chunk));
			end
		end
	end

	// Watchdog on cycles with no item moving on either channel
	always @(posedge clk) begin
		if ((word_valid && word_ready) || (chunk_valid && chunk_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WatchdogLimit) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Single-word extremes and punctuation bytes, then end-around carry over multi-word messages
	task automatic test_single_word_extremes();
		load_seed(32'h0000_0000);
		offer_word(32'h0000_0000, 1'b1);
		offer_word(32'hFFFF_FFFF, 1'b1);
		offer_word(32'h0000_0001, 1'b1);
		offer_word(32'h8000_0000, 1'b1);
		offer_word(32'h7FFF_FFFF, 1'b1);
		// complement bytes of the first word sit on both punctuation ranges
		offer_word(32'hD7BC_533C, 1'b1);
		offer_word(32'h5A5A_A5A5, 1'b1);
		// carry out of bit 31 wraps back in
		offer_word(32'hFFFF_FFFF, 1'b0);
		offer_word(32'h0000_0001, 1'b1);
		offer_word(32'h8000_0000, 1'b0);
		offer_word(32'h8000_0000, 1'b0);
		offer_word(32'h0000_0000, 1'b1);
		settle_idle();
	endtask

	task automatic test_seed_extremes();
		load_seed(32'hFFFF_FFFF);
		offer_word(32'h0000_0000, 1'b1);
		offer_word(32'hFFFF_FFFF, 1'b1);
		settle_idle();
		load_seed(32'h8000_0000);
		offer_word(32'h8000_0000, 1'b1);
		settle_idle();
	endtask

	// A seed written while a message is open applies only to the next message
	task automatic test_seed_mid_message();
		load_seed(32'h1234_5678);
		offer_word(32'hCAFE_F00D, 1'b0);
		settle_idle();
		load_seed(32'hFEDC_BA98);
		offer_word(32'h0BAD_BEEF, 1'b1);
		offer_word(32'h0000_0000, 1'b1);
		settle_idle();
	endtask

	// Receiver holds off while words keep coming, so the block backs up
	task automatic test_output_backpressure();
		int m;
		hold_cycles = HoldOffCycles;
		for (m = 0; m < 6; m++)
			send_message(2);
		settle_idle();
	endtask

	task automatic test_random_messages();
		int phase, sent, len;
		for (phase = 0; phase < NumPhases; phase++) begin
			case (phase)
				0: load_seed(32'h0000_0000);
				1: load_seed(32'hFFFF_FFFF);
				default: load_seed($urandom);
			endcase
			// final phase runs with no idling on either side
			word_gaps_on = (phase != 2) && (phase != NumPhases - 1);
			chunk_stalls_on = (phase != 3) && (phase != NumPhases - 1);
			sent = 0;
			while (sent < WordsPerPhase) begin
				len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 8);
				send_message(len);
				sent += len;
			end
			settle_idle();
		end
	endtask

	initial begin
		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_single_word_extremes();
		test_seed_extremes();
		test_seed_mid_message();
		test_output_backpressure();
		test_random_messages();
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: sim.f
design/occ_pkg.sv
design/occ_ctrl.sv
design/occ_dpath.sv
design/ones_complement_checksum_ascii_encode.sv
dv/ones_complement_checksum_ascii_encode_tb.sv
